[src/bgtp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgtp_pkg
// Shared types and constants of the block grammar token parser.
// ----------------------------------------------------------------------------
package bgtp_pkg;

    localparam int unsigned DEPTH_W   = 16;
    localparam int unsigned ARGS_W    = 8;
    localparam int unsigned MAX_DEPTH = 65535;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);
    localparam logic [ARGS_W-1:0]  ARGS_MAX    = '1;

    typedef enum logic [2:0] {
        K_EOI     = 3'd0,
        K_BARE    = 3'd1,
        K_COMMENT = 3'd2,
        K_CODE    = 3'd3,
        K_LIT     = 3'd4,
        K_QUOTED  = 3'd5,
        K_OTHER   = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_SHIFT_NAME = 4'd1,
        EV_COMMAND    = 4'd2,
        EV_COMMENT    = 4'd3,
        EV_CODE       = 4'd4,
        EV_BLOCK_HDR  = 4'd5,
        EV_BODY_START = 4'd6,
        EV_BODY_END   = 4'd7,
        EV_EOI        = 4'd8
    } t_event;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_EOI_OPEN   = 3'd1,
        ERR_UNMATCHED  = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_LITERAL    = 3'd4,
        ERR_INVALID    = 3'd5
    } t_error;

    typedef enum logic [4:0] {
        ST_TOP     = 5'b00001,
        ST_NAME    = 5'b00010,
        ST_ARG     = 5'b00100,
        ST_ARGCONT = 5'b01000,
        ST_TAIL    = 5'b10000
    } t_gstate;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] literal_char;
    } t_token;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [2:0]         error_code;
        logic [ARGS_W-1:0]  arg_count;
        logic [DEPTH_W-1:0] nest_depth;
    } t_result;

endpackage
`default_nettype wire

[src/block_grammar_token_parser_core.sv]
`default_nettype none
// A token parser for a brace-structured block grammar. Each input transaction
// carries one lexer token and yields exactly one result transaction with the
// grammar event, an error code, the block argument count and the nesting
// depth after the token. One token is taken every cycle while the output is
// not stalled; a token is held in the input register, and its result is
// captured in the result register when it moves on. The grammar state and
// depth update is combinational between the two registers.
// ----------------------------------------------------------------------------
// block_grammar_token_parser_core
// Top level: input register, grammar stage and result register.
// ----------------------------------------------------------------------------
module block_grammar_token_parser_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire bgtp_pkg::t_token  i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output bgtp_pkg::t_result      o_out_data,
    input  wire logic              i_out_stall
);

    logic              w_tok_valid;
    bgtp_pkg::t_token  w_tok;
    logic              w_advance;
    bgtp_pkg::t_result w_result;
    logic              r_out_valid;
    logic              n_out_valid;
    bgtp_pkg::t_result r_out_data;

    assign w_advance = w_tok_valid && (!r_out_valid || !i_out_stall);

    bgtp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .i_advance (w_advance),
        .o_stall   (o_in_stall),
        .o_valid   (w_tok_valid),
        .o_data    (w_tok)
    );

    bgtp_grammar u_grammar (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (w_tok),
        .i_commit (w_advance),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

[src/bgtp_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgtp_in_reg
// Input register: captures one token transaction and holds it until the
// grammar stage commits it.
// ----------------------------------------------------------------------------
module bgtp_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire bgtp_pkg::t_token i_data,
    input  wire logic            i_advance,
    output logic                 o_stall,
    output logic                 o_valid,
    output bgtp_pkg::t_token     o_data
);

    logic             r_valid;
    logic             n_valid;
    bgtp_pkg::t_token r_data;
    logic             w_load;

    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[src/bgtp_grammar.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgtp_grammar
// Grammar state, nesting depth and argument count; computes the result of
// one token and commits the new state when the result moves on.
// ----------------------------------------------------------------------------
module bgtp_grammar (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bgtp_pkg::t_token i_token,
    input  wire logic             i_commit,
    output bgtp_pkg::t_result     o_result
);

    bgtp_pkg::t_gstate              r_state;
    bgtp_pkg::t_gstate              n_state;
    logic [bgtp_pkg::DEPTH_W-1:0]   r_depth;
    logic [bgtp_pkg::DEPTH_W-1:0]   n_depth;
    logic [bgtp_pkg::ARGS_W-1:0]    r_args;
    logic [bgtp_pkg::ARGS_W-1:0]    n_args;
    bgtp_pkg::t_event               w_ev;
    bgtp_pkg::t_error               w_err;
    logic [bgtp_pkg::ARGS_W-1:0]    w_cnt;
    logic                           w_lit;
    logic                           w_word;
    logic [7:0]                     w_ch;

    assign w_ch   = i_token.literal_char;
    assign w_lit  = (i_token.token_kind == bgtp_pkg::K_LIT);
    assign w_word = (i_token.token_kind == bgtp_pkg::K_BARE)
                 || (i_token.token_kind == bgtp_pkg::K_QUOTED);

    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        n_args  = r_args;
        w_ev    = bgtp_pkg::EV_NONE;
        w_err   = bgtp_pkg::ERR_OK;
        w_cnt   = '0;
        case (r_state)
            bgtp_pkg::ST_TOP, bgtp_pkg::ST_TAIL: begin
                if (i_token.token_kind == bgtp_pkg::K_EOI) begin
                    if (r_depth == '0) begin
                        w_ev = bgtp_pkg::EV_EOI;
                    end else begin
                        w_err = bgtp_pkg::ERR_EOI_OPEN;
                    end
                end else if (i_token.token_kind == bgtp_pkg::K_BARE) begin
                    w_ev    = bgtp_pkg::EV_SHIFT_NAME;
                    n_state = bgtp_pkg::ST_NAME;
                end else if (i_token.token_kind == bgtp_pkg::K_COMMENT) begin
                    w_ev    = bgtp_pkg::EV_COMMENT;
                    n_state = bgtp_pkg::ST_TOP;
                end else if (i_token.token_kind == bgtp_pkg::K_CODE) begin
                    w_ev    = bgtp_pkg::EV_CODE;
                    n_state = bgtp_pkg::ST_TOP;
                end else if (w_lit && w_ch == bgtp_pkg::CH_RBRACE) begin
                    if (r_depth == '0) begin
                        w_err = bgtp_pkg::ERR_UNMATCHED;
                    end else begin
                        n_depth = r_depth - 1'b1;
                        w_ev    = bgtp_pkg::EV_BODY_END;
                        n_state = bgtp_pkg::ST_TOP;
                    end
                end else if (w_lit && w_ch == bgtp_pkg::CH_LBRACE
                             && r_state == bgtp_pkg::ST_TAIL) begin
                    if (r_depth >= bgtp_pkg::DEPTH_LIMIT) begin
                        w_err = bgtp_pkg::ERR_DEPTH;
                    end else begin
                        n_depth = r_depth + 1'b1;
                        w_ev    = bgtp_pkg::EV_BODY_START;
                        n_state = bgtp_pkg::ST_TOP;
                    end
                end else if (w_lit) begin
                    w_err = bgtp_pkg::ERR_LITERAL;
                end else begin
                    w_err = bgtp_pkg::ERR_INVALID;
                end
            end
            bgtp_pkg::ST_NAME: begin
                if (w_word) begin
                    w_ev    = bgtp_pkg::EV_COMMAND;
                    n_state = bgtp_pkg::ST_TOP;
                end else if (w_lit && w_ch == bgtp_pkg::CH_LPAREN) begin
                    n_args  = '0;
                    n_state = bgtp_pkg::ST_ARG;
                end else if (w_lit) begin
                    w_err = bgtp_pkg::ERR_LITERAL;
                end else begin
                    w_err = bgtp_pkg::ERR_INVALID;
                end
            end
            bgtp_pkg::ST_ARG: begin
                if (w_word) begin
                    if (r_args != bgtp_pkg::ARGS_MAX) begin
                        n_args = r_args + 1'b1;
                    end
                    n_state = bgtp_pkg::ST_ARGCONT;
                end else if (w_lit && w_ch == bgtp_pkg::CH_RPAREN) begin
                    w_ev    = bgtp_pkg::EV_BLOCK_HDR;
                    w_cnt   = r_args;
                    n_state = bgtp_pkg::ST_TAIL;
                end else if (w_lit) begin
                    w_err = bgtp_pkg::ERR_LITERAL;
                end else begin
                    w_err = bgtp_pkg::ERR_INVALID;
                end
            end
            bgtp_pkg::ST_ARGCONT: begin
                if (!w_lit) begin
                    w_err = bgtp_pkg::ERR_INVALID;
                end else if (w_ch == bgtp_pkg::CH_COMMA) begin
                    n_state = bgtp_pkg::ST_ARG;
                end else if (w_ch == bgtp_pkg::CH_RPAREN) begin
                    w_ev    = bgtp_pkg::EV_BLOCK_HDR;
                    w_cnt   = r_args;
                    n_state = bgtp_pkg::ST_TAIL;
                end else begin
                    w_err = bgtp_pkg::ERR_LITERAL;
                end
            end
            default: begin
                w_err = bgtp_pkg::ERR_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgtp_pkg::ST_TOP;
            r_depth <= '0;
            r_args  <= '0;
        end else if (i_commit) begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_args  <= n_args;
        end
    end

    assign o_result.event_res  = w_ev;
    assign o_result.error_code = w_err;
    assign o_result.arg_count  = w_cnt;
    assign o_result.nest_depth = n_depth;

endmodule
`default_nettype wire

[src/bgtp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgtp_checker
// Port-level checks of the token parser, bound to the top level.
// ----------------------------------------------------------------------------
module bgtp_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire bgtp_pkg::t_token  i_in_data,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire bgtp_pkg::t_result o_out_data,
    input wire logic              i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed");

    a_err_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code != bgtp_pkg::ERR_OK
        |-> o_out_data.event_res == bgtp_pkg::EV_NONE)
        else $error("error result carries an event");

    a_count_hdr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != bgtp_pkg::EV_BLOCK_HDR
        |-> o_out_data.arg_count == '0)
        else $error("argument count outside block header");

    a_body_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == bgtp_pkg::EV_BODY_START
        |-> o_out_data.nest_depth != '0)
        else $error("body start at depth zero");

    a_eoi_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == bgtp_pkg::EV_EOI
        |-> o_out_data.nest_depth == '0)
        else $error("end of input at nonzero depth");

endmodule

bind block_grammar_token_parser_core bgtp_checker u_bgtp_checker (.*);
`default_nettype wire
